// ----- sv/hml_pkg.sv -----
package hml_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_EQ  = 2'd0,
    OP_LOAD_REF = 2'd1,
    OP_BUILD    = 2'd2,
    OP_MAP      = 2'd3
  } hml_op_t;

  typedef enum logic {
    KIND_BUILD_DONE = 1'b0,
    KIND_MAPPED     = 1'b1
  } hml_kind_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_ZERO,
    CNT_TOP,
    CNT_INC,
    CNT_DEC
  } hml_cnt_op_t;

  typedef struct packed {
    logic        load_eq;
    logic        load_ref;
    logic        map_eq;
    logic        map_inv;
    logic        clr_en;
    logic        scan_rd;
    logic        fill_rd;
    logic        prev_clr;
    logic        out_load;
    hml_kind_t   out_kind;
    hml_cnt_op_t cnt_op;
  } hml_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_zero;
    logic out_free;
  } hml_status_t;

endpackage

// ----- sv/hml_ctrl.sv -----
module hml_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_ready,
  input  hml_pkg::hml_status_t status,
  output hml_pkg::hml_cmd_t    cmd
);
  import hml_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_INV,
    S_MAP_OUT,
    S_CLEAR,
    S_SCAN,
    S_SCAN_END,
    S_FILL,
    S_FILL_END,
    S_DONE
  } state_t;

  state_t state, state_next;
  hml_op_t op;

  assign op = hml_op_t'(in_op);

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.cnt_op = CNT_HOLD;
    cmd.out_kind = KIND_BUILD_DONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op)
            OP_LOAD_EQ:  cmd.load_eq = 1'b1;
            OP_LOAD_REF: cmd.load_ref = 1'b1;
            OP_BUILD: begin
              cmd.cnt_op = CNT_ZERO;
              state_next = S_CLEAR;
            end
            OP_MAP: begin
              cmd.map_eq = 1'b1;
              state_next = S_MAP_INV;
            end
            default: ;
          endcase
        end
      end
      S_MAP_INV: begin
        cmd.map_inv = 1'b1;
        state_next  = S_MAP_OUT;
      end
      S_MAP_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_MAPPED;
          state_next   = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.cnt_last) begin
          cmd.cnt_op = CNT_TOP;
          state_next = S_SCAN;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.cnt_zero) begin
          state_next = S_SCAN_END;
        end else begin
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_SCAN_END: begin
        cmd.cnt_op   = CNT_ZERO;
        cmd.prev_clr = 1'b1;
        state_next   = S_FILL;
      end
      S_FILL: begin
        cmd.fill_rd = 1'b1;
        if (status.cnt_last) begin
          state_next = S_FILL_END;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      S_FILL_END: state_next = S_DONE;
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_BUILD_DONE;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/hml_datapath.sv -----
module hml_datapath #(
  parameter int LEVELS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           table_index,
  input  logic [7:0]           table_value,
  input  logic [7:0]           pixel,
  input  hml_pkg::hml_cmd_t    cmd,
  output hml_pkg::hml_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [7:0]           out_pixel
);
  import hml_pkg::*;

  localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int XW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [XW-1:0] LEVELS_X = XW'(LEVELS);
  localparam logic [AW-1:0] CNT_TOP_VAL = AW'(LEVELS - 1);

  logic [7:0] eq_mem    [LEVELS];
  logic [7:0] ref_mem   [LEVELS];
  logic [7:0] inv_mem   [LEVELS];
  logic [8:0] match_mem [LEVELS];

  logic [AW-1:0] cnt;

  // load addressing
  logic [XW-1:0] ld_x;
  logic          ld_ok;
  logic [AW-1:0] ld_addr;
  assign ld_x    = XW'(table_index);
  assign ld_ok   = ld_x < LEVELS_X;
  assign ld_addr = ld_x[AW-1:0];

  // map addressing
  logic [XW-1:0] pix_x;
  logic [AW-1:0] pix_addr;
  logic [7:0]    eq_rd;
  logic          eq_oor;
  logic [7:0]    e_eff;
  logic [XW-1:0] e_x;
  logic [AW-1:0] e_addr;
  logic [7:0]    inv_rd;
  logic          inv_oor;
  assign pix_x    = XW'(pixel);
  assign pix_addr = pix_x[AW-1:0];
  assign e_eff    = eq_oor ? 8'd0 : eq_rd;
  assign e_x      = XW'(e_eff);
  assign e_addr   = e_x[AW-1:0];

  // scan pipeline
  logic          scan_v;
  logic [AW-1:0] scan_j;
  logic [7:0]    ref_rd;
  logic [XW-1:0] v_x;
  logic [XW-1:0] j_x;
  logic          scan_wr;
  assign v_x     = XW'(ref_rd);
  assign j_x     = XW'(scan_j);
  assign scan_wr = scan_v && (v_x < LEVELS_X);

  // match write port
  logic          m_we;
  logic [AW-1:0] m_waddr;
  logic [8:0]    m_wdata;
  always_comb begin
    m_we    = 1'b0;
    m_waddr = cnt;
    m_wdata = '0;
    priority if (cmd.clr_en) begin
      m_we = 1'b1;
    end else if (scan_wr) begin
      m_we    = 1'b1;
      m_waddr = v_x[AW-1:0];
      m_wdata = {1'b1, j_x[7:0]};
    end else begin
      m_we = 1'b0;
    end
  end

  // fill pipeline
  logic          fill_v;
  logic [AW-1:0] fill_i;
  logic [8:0]    match_rd;
  logic [7:0]    prev;
  logic [7:0]    entry;
  assign entry = match_rd[8] ? match_rd[7:0] : prev + 8'd1;

  always_ff @(posedge clk) begin
    if (cmd.load_eq && ld_ok) eq_mem[ld_addr] <= table_value;
    if (cmd.map_eq) eq_rd <= eq_mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ref && ld_ok) ref_mem[ld_addr] <= table_value;
    if (cmd.scan_rd) ref_rd <= ref_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (m_we) match_mem[m_waddr] <= m_wdata;
    if (cmd.fill_rd) match_rd <= match_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (fill_v) inv_mem[fill_i] <= entry;
    if (cmd.map_inv) inv_rd <= inv_mem[e_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.map_eq) eq_oor <= !(pix_x < LEVELS_X);
    if (cmd.map_inv) inv_oor <= !(e_x < LEVELS_X);
    scan_j <= cnt;
    fill_i <= cnt;
    if (cmd.prev_clr) begin
      prev <= 8'd0;
    end else if (fill_v) begin
      prev <= entry;
    end
    if (cmd.out_load) begin
      out_kind  <= cmd.out_kind;
      out_pixel <= (cmd.out_kind == KIND_MAPPED && !inv_oor) ? inv_rd : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      scan_v    <= 1'b0;
      fill_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      scan_v <= cmd.scan_rd;
      fill_v <= cmd.fill_rd;
      unique case (cmd.cnt_op)
        CNT_HOLD: cnt <= cnt;
        CNT_ZERO: cnt <= '0;
        CNT_TOP:  cnt <= CNT_TOP_VAL;
        CNT_INC:  cnt <= cnt + AW'(1);
        CNT_DEC:  cnt <= cnt - AW'(1);
        default:  cnt <= cnt;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.cnt_last = (cnt == CNT_TOP_VAL);
  assign status.cnt_zero = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- sv/histogram_matching_lut.sv -----
// Histogram-matching lookup for grey pixels. Input transfers carry an opcode
// in s_tuser: load an entry of the input equalization table or the reference
// equalization table (no result), build the inverse table (one result of kind
// "build done"), or map a pixel (one result holding inverse[eq[pixel]]). A map
// passes through two dependent table reads and the output register. A build is
// a clear pass, a descending scan of the reference table into a first-match
// memory and an ascending fill of the inverse table, each one entry per cycle
// on its memory port. One item is worked on at a time; the output register
// lets the next item be taken while a result waits.
module histogram_matching_lut #(
  parameter int LEVELS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // table_index[7:0], table_value[15:8], pixel[23:16]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // matched_pixel[7:0]
  output logic        m_tuser    // result_kind[0]
);
  import hml_pkg::*;

  hml_cmd_t    cmd;
  hml_status_t status;

  hml_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  hml_datapath #(
    .LEVELS (LEVELS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .table_index (s_tdata[7:0]),
    .table_value (s_tdata[15:8]),
    .pixel       (s_tdata[23:16]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_kind    (m_tuser),
    .out_pixel   (m_tdata)
  );

endmodule

// ----- tb/sv/hml_match_checker.sv -----
module hml_match_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // table_index[7:0], table_value[15:8], pixel[23:16]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // matched_pixel[7:0]
  input  logic        m_tuser,   // result_kind[0]
  output int          n_fail,
  output int          n_pending,
  output int          n_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import hml_pkg::*;

  typedef struct packed {
    hml_kind_t  kind;
    logic [7:0] pixel;
  } match_result_t;

  logic [7:0]    eq_lut  [256];
  logic [7:0]    ref_lut [256];
  logic [7:0]    inv_lut [256];
  match_result_t pending_results_q[$];

  // Inverse entry for a level: first ref index holding that level, else previous + 1.
  function automatic void build_inverse_lut();
    logic [7:0] prev;
    logic [7:0] entry;
    prev = 8'd0;
    for (int lvl = 0; lvl < 256; lvl++) begin
      entry = prev + 8'd1;
      for (int j = 0; j < 256; j++) begin
        if (ref_lut[j] == lvl[7:0]) begin
          entry = j[7:0];
          break;
        end
      end
      inv_lut[lvl] = entry;
      prev = entry;
    end
  endfunction

  always @(posedge clk) begin : watch
    match_result_t want;
    logic [7:0]    idx;
    logic [7:0]    val;
    logic [7:0]    pix;
    if (rst) begin
      pending_results_q.delete();
      n_fail = 0;
      n_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (pending_results_q.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result: expected none, got kind %0d pixel %0d",
                   $time, m_tuser, m_tdata);
        end else begin
          want = pending_results_q.pop_front();
          if (m_tuser !== want.kind) begin
            n_fail++;
            $display("%0t: result kind mismatch: expected %0d, got %0d",
                     $time, want.kind, m_tuser);
          end
          if (m_tdata !== want.pixel) begin
            n_fail++;
            $display("%0t: matched pixel mismatch: expected %0d, got %0d",
                     $time, want.pixel, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[7:0];
        val = s_tdata[15:8];
        pix = s_tdata[23:16];
        case (s_tuser)
          OP_LOAD_EQ:  eq_lut[idx] = val;
          OP_LOAD_REF: ref_lut[idx] = val;
          OP_BUILD: begin
            build_inverse_lut();
            pending_results_q.push_back('{KIND_BUILD_DONE, 8'd0});
          end
          default: begin
            pending_results_q.push_back('{KIND_MAPPED, inv_lut[eq_lut[pix]]});
          end
        endcase
      end
    end
    n_pending = pending_results_q.size();
  end

endmodule

// ----- tb/sv/tb_histogram_matching_lut.sv -----
module tb_histogram_matching_lut;
  timeunit 1ns;
  timeprecision 1ps;
  import hml_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // table_index[7:0], table_value[15:8], pixel[23:16]
  logic [1:0]  s_tuser;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;   // matched_pixel[7:0]
  logic        m_tuser;   // result_kind[0]

  int fail_count;
  int pending_count;
  int checked_count;
  int n_loads;
  int n_builds;
  int n_maps;
  int stall_left = 0;
  bit idle_on;

  histogram_matching_lut i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  hml_match_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .n_fail    (fail_count),
    .n_pending (pending_count),
    .n_checked (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result-side backpressure in random bursts while idle_on is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send(hml_op_t op, logic [7:0] index, logic [7:0] value,
                      logic [7:0] pixel);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pixel, value, index};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    case (op)
      OP_BUILD: n_builds++;
      OP_MAP:   n_maps++;
      default:  n_loads++;
    endcase
  endtask

  task automatic map_pixel(logic [7:0] pixel);
    send(OP_MAP, 8'($urandom), 8'($urandom), pixel);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    logic [7:0] v;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_LOAD_EQ;
    idle_on = 1'b1;
    n_loads = 0;
    n_builds = 0;
    n_maps = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // fill both tables: eq is identity; ref has no level 0, a plus-one chain
    // that wraps past 255, and many duplicate entries
    for (int i = 0; i < 256; i++) send(OP_LOAD_EQ, i[7:0], i[7:0], 8'($urandom));
    for (int i = 0; i < 255; i++) send(OP_LOAD_REF, i[7:0], 8'd7, 8'($urandom));
    send(OP_LOAD_REF, 8'd255, 8'd100, 8'($urandom));
    send(OP_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
    map_pixel(8'd0);
    map_pixel(8'd1);
    map_pixel(8'd7);
    map_pixel(8'd8);
    map_pixel(8'd100);
    map_pixel(8'd101);
    map_pixel(8'd255);

    // extremes of index and value, a moved first match, eq rewritten under a map
    send(OP_LOAD_REF, 8'd0, 8'd0, 8'hff);
    send(OP_LOAD_REF, 8'd255, 8'd255, 8'h00);
    send(OP_LOAD_REF, 8'd128, 8'd7, 8'h5a);
    send(OP_BUILD, 8'hff, 8'hff, 8'hff);
    map_pixel(8'd0);
    send(OP_LOAD_EQ, 8'd0, 8'd255, 8'ha5);
    send(OP_LOAD_EQ, 8'd255, 8'd0, 8'h00);
    map_pixel(8'd0);
    map_pixel(8'd255);
    map_pixel(8'd7);
    map_pixel(8'd128);

    drain_results();

    for (int k = 0; k < 400; k++) begin
      if (k == 320) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send(OP_LOAD_EQ, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 55) begin
        if ($urandom_range(0, 1) == 0) v = 8'($urandom);
        else v = 8'($urandom_range(0, 15));
        send(OP_LOAD_REF, 8'($urandom), v, 8'($urandom));
      end else if (pick < 58) begin
        send(OP_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        map_pixel(8'($urandom));
      end
    end

    drain_results();
    repeat (50) @(posedge clk);

    $display("Run sent %0d table loads, %0d inverse builds and %0d pixel maps,",
             n_loads, n_builds, n_maps);
    $display("with random gaps and backpressure; %0d results compared.", checked_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/hml_pkg.sv
sv/hml_ctrl.sv
sv/hml_datapath.sv
sv/histogram_matching_lut.sv
tb/sv/hml_match_checker.sv
tb/sv/tb_histogram_matching_lut.sv
